// File: rtl/core/iir4mc_pkg.sv
`default_nettype none

package iir4mc_pkg;

  localparam int SMP_W        = 16;
  localparam int CH_W         = 2;
  localparam int TAPS         = 4;
  localparam int FRAC_BITS    = 14;
  localparam int COEF_W       = 16;
  localparam int PROD_W       = 32;
  localparam int ACC_W        = 40;
  localparam int CHANNELS_DEF = 3;

  typedef logic signed [SMP_W-1:0] smp_t;

  // x[0] and y[0] hold the most recent sample of the channel
  typedef struct packed {
    smp_t [TAPS-1:0] x;
    smp_t [TAPS-1:0] y;
  } hist_t;

  // high-pass coefficients, signed q2.14
  localparam logic signed [COEF_W-1:0] COEF_B [TAPS+1] =
    '{16'sd1299, -16'sd5200, 16'sd7799, -16'sd5200, 16'sd1299};
  localparam logic signed [COEF_W-1:0] COEF_A [TAPS] =
    '{16'sd4999, 16'sd14421, 16'sd5859, 16'sd3388};

  function automatic logic signed [PROD_W-1:0] smul(logic signed [COEF_W-1:0] c, smp_t s);
    logic signed [PROD_W-1:0] ce;
    logic signed [PROD_W-1:0] se;
    ce = PROD_W'(c);
    se = PROD_W'(s);
    return ce * se;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/iir4mc_arith.sv
`default_nettype none

module iir4mc_arith (
  input  logic                clk_i,
  input  logic                en_i,
  input  iir4mc_pkg::smp_t    sample_i,
  input  iir4mc_pkg::hist_t   hist_i,
  output iir4mc_pkg::smp_t    filtered_o
);

  localparam int PW = iir4mc_pkg::PROD_W;
  localparam int AW = iir4mc_pkg::ACC_W;
  localparam int NT = iir4mc_pkg::TAPS;
  localparam int FB = iir4mc_pkg::FRAC_BITS;
  localparam int SW = iir4mc_pkg::SMP_W;

  localparam logic signed [AW-1:0] RND_HALF = AW'(2 ** (FB - 1));
  localparam logic signed [AW-1:0] SAT_MAX  = AW'(2 ** (SW - 1) - 1);
  localparam logic signed [AW-1:0] SAT_MIN  = AW'(-(2 ** (SW - 1)));

  logic signed [PW-1:0] bp_q [NT+1];
  logic signed [PW-1:0] ap_q [NT];

  logic signed [AW-1:0] acc;
  logic signed [AW-1:0] rnd;
  logic signed [AW-1:0] quo;

  // product stage
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bp_q[0] <= iir4mc_pkg::smul(iir4mc_pkg::COEF_B[0], sample_i);
      for (int k = 1; k <= NT; k++) begin
        bp_q[k]   <= iir4mc_pkg::smul(iir4mc_pkg::COEF_B[k], hist_i.x[k-1]);
        ap_q[k-1] <= iir4mc_pkg::smul(iir4mc_pkg::COEF_A[k-1], hist_i.y[k-1]);
      end
    end
  end

  // sum, round to nearest, saturate
  always_comb begin
    acc = AW'(bp_q[0]);
    for (int k = 1; k <= NT; k++) begin
      acc = acc + AW'(bp_q[k]) - AW'(ap_q[k-1]);
    end
    rnd = acc + RND_HALF;
    quo = rnd >>> FB;
    if (quo > SAT_MAX) begin
      filtered_o = SW'(SAT_MAX);
    end else if (quo < SAT_MIN) begin
      filtered_o = SW'(SAT_MIN);
    end else begin
      filtered_o = SW'(quo);
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/iir_fourth_order_multichannel_core.sv
`default_nettype none

// Fourth-order direct form I high-pass filter shared by up to CHANNELS channels. Each item
// carries a 16-bit signed sample and a channel number; one filtered, rounded and saturated
// result comes back per item, in order, with the channel echoed. An item on an unknown channel
// gives zero and leaves all history alone. Per-channel history (four inputs, four outputs)
// sits in one row of a synchronous memory and is read, updated and written back per item;
// rows read as zero until first written, so no clearing pass follows reset. Items are taken
// one per cycle while consecutive items use different channels and the output does not stall;
// an item on the channel of the item accepted just before it waits until that item's multiply
// stage writes back, because that item's history row is only final after its multiply stage (the
// row is then bypassed from the write-back port).
module iir_fourth_order_multichannel_core #(
  parameter int CHANNELS = iir4mc_pkg::CHANNELS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [iir4mc_pkg::SMP_W-1:0] sample_i,
  input  logic [iir4mc_pkg::CH_W-1:0]    channel_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [iir4mc_pkg::SMP_W-1:0] filtered_o,
  output logic [iir4mc_pkg::CH_W-1:0]    channel_out_o
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CW    = iir4mc_pkg::CH_W;
  localparam int NT    = iir4mc_pkg::TAPS;

  iir4mc_pkg::hist_t mem_q [CHANNELS];
  logic [CHANNELS-1:0] row_vld_q;

  // read stage
  logic              r_valid_q;
  logic              r_oor_q;
  logic              r_byp_q;
  logic              r_rvld_q;
  logic [CW-1:0]     r_ch_q;
  iir4mc_pkg::smp_t  r_x_q;
  iir4mc_pkg::hist_t rd_row_q;
  iir4mc_pkg::hist_t byp_row_q;
  iir4mc_pkg::hist_t r_row;

  // multiply stage
  logic              m_valid_q;
  logic              m_oor_q;
  logic [CW-1:0]     m_ch_q;
  iir4mc_pkg::smp_t  m_x_q;
  iir4mc_pkg::hist_t m_hist_q;
  iir4mc_pkg::smp_t  y_new;
  iir4mc_pkg::hist_t wr_row;

  // output register
  logic              o_valid_q;
  iir4mc_pkg::smp_t  o_filtered_q;
  logic [CW-1:0]     o_ch_q;

  logic             o_free, m_go, m_free, r_go, r_free;
  logic             in_rng, hazard, byp, acc_in, wr_en;
  logic [IDX_W-1:0] in_idx, wr_idx;

  assign o_free = !o_valid_q || out_ready_i;
  assign m_go   = m_valid_q && o_free;
  assign m_free = !m_valid_q || m_go;
  assign r_go   = r_valid_q && m_free;
  assign r_free = !r_valid_q || r_go;

  assign in_rng = 32'(channel_i) < 32'(CHANNELS);
  assign in_idx = IDX_W'(channel_i);
  assign wr_idx = IDX_W'(m_ch_q);
  assign wr_en  = m_go && !m_oor_q;

  assign hazard = in_rng && ((r_valid_q && r_ch_q == channel_i) ||
                             (m_valid_q && !m_go && m_ch_q == channel_i));
  assign byp    = wr_en && m_ch_q == channel_i;

  assign in_ready_o = r_free && !hazard;
  assign acc_in     = in_valid_i && in_ready_o;

  assign wr_row.x = {m_hist_q.x[NT-2:0], m_x_q};
  assign wr_row.y = {m_hist_q.y[NT-2:0], y_new};

  always_comb begin
    if (r_byp_q) begin
      r_row = byp_row_q;
    end else if (r_rvld_q) begin
      r_row = rd_row_q;
    end else begin
      r_row = '0;
    end
  end

  // history memory
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_idx] <= wr_row;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_in && in_rng) begin
      rd_row_q <= mem_q[in_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      r_valid_q <= 1'b0;
      m_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (wr_en) begin
        row_vld_q[wr_idx] <= 1'b1;
      end
      if (r_free) begin
        r_valid_q <= acc_in;
      end
      if (m_free) begin
        m_valid_q <= r_valid_q;
      end
      if (o_free) begin
        o_valid_q <= m_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      r_oor_q   <= !in_rng;
      r_ch_q    <= channel_i;
      r_x_q     <= sample_i;
      r_byp_q   <= byp;
      r_rvld_q  <= in_rng && row_vld_q[in_idx];
      byp_row_q <= wr_row;
    end
    if (r_go) begin
      m_oor_q  <= r_oor_q;
      m_ch_q   <= r_ch_q;
      m_x_q    <= r_x_q;
      m_hist_q <= r_row;
    end
    if (m_go) begin
      o_filtered_q <= m_oor_q ? '0 : y_new;
      o_ch_q       <= m_ch_q;
    end
  end

  iir4mc_arith u_arith (
    .clk_i      (clk_i),
    .en_i       (r_go),
    .sample_i   (r_x_q),
    .hist_i     (r_row),
    .filtered_o (y_new)
  );

  assign out_valid_o   = o_valid_q;
  assign filtered_o    = o_filtered_q;
  assign channel_out_o = o_ch_q;

endmodule

`default_nettype wire

// File: rtl/core/iir4mc_checker.sv
`default_nettype none

module iir4mc_checker #(
  parameter int CHANNELS = iir4mc_pkg::CHANNELS_DEF
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic signed [iir4mc_pkg::SMP_W-1:0] sample_i,
  input logic [iir4mc_pkg::CH_W-1:0]    channel_i,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic signed [iir4mc_pkg::SMP_W-1:0] filtered_o,
  input logic [iir4mc_pkg::CH_W-1:0]    channel_out_o
);

  logic [2:0] cnt_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // items inside the block
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (in_acc && !out_acc) begin
      cnt_q <= cnt_q + 3'd1;
    end else if (out_acc && !in_acc) begin
      cnt_q <= cnt_q - 3'd1;
    end
  end

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(sample_i) &&
    $stable(channel_i))
    else $error("input item changed while waiting");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(filtered_o) &&
    $stable(channel_out_o))
    else $error("output item changed while stalled");

  a_bad_channel_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (32'(channel_out_o) >= 32'(CHANNELS)) |-> filtered_o == '0)
    else $error("unknown channel gave a non-zero result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cnt_q != 3'd0)
    else $error("result without an accepted item");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd3)
    else $error("more items in flight than stages");

endmodule

bind iir_fourth_order_multichannel_core iir4mc_checker #(.CHANNELS(CHANNELS)) u_checker (.*);

`default_nettype wire

// File: tb/iir_fourth_order_multichannel_core_tb.sv
`timescale 1ns / 100ps

module iir_fourth_order_multichannel_core_tb;

  localparam int TAPS         = iir4mc_pkg::TAPS;
  localparam int CH_W         = iir4mc_pkg::CH_W;
  localparam int FRAC_BITS    = iir4mc_pkg::FRAC_BITS;
  localparam int CHANNELS_DEF = iir4mc_pkg::CHANNELS_DEF;

  typedef iir4mc_pkg::smp_t smp_t;

  localparam int HP_B [TAPS+1] = '{1299, -5200, 7799, -5200, 1299};
  localparam int HP_A [TAPS] = '{4999, 14421, 5859, 3388};
  localparam int MAX_IDLE = 18;
  localparam int RANDOM_ITEMS = 1800;
  localparam logic [CH_W-1:0] BAD_CH = CH_W'(CHANNELS_DEF);
  localparam logic [CH_W-1:0] CH0 = CH_W'(0);
  localparam logic [CH_W-1:0] CH1 = CH_W'(1);
  localparam logic [CH_W-1:0] CH2 = CH_W'(2);

  typedef struct {
    smp_t            filtered;
    logic [CH_W-1:0] ch;
  } filt_out_t;

  typedef enum int {
    MIX_RANDOM,
    MIX_EXTREME,
    MIX_NYQUIST,
    MIX_TINY,
    MIX_SAME_CH,
    MIX_ROUND_ROBIN
  } stim_mix_e;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid_i = 1'b0;
  logic            in_ready_o;
  smp_t            sample_i = '0;
  logic [CH_W-1:0] channel_i = '0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  smp_t            filtered_o;
  logic [CH_W-1:0] channel_out_o;

  smp_t      x_hist [CHANNELS_DEF][TAPS] = '{default: '0};
  smp_t      y_hist [CHANNELS_DEF][TAPS] = '{default: '0};
  filt_out_t pending_results [$];
  int        error_count = 0;
  bit        in_idle = 1'b1;
  bit        out_idle = 1'b1;

  iir_fourth_order_multichannel_core #(
    .CHANNELS(CHANNELS_DEF)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_i     (sample_i),
    .channel_i    (channel_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .filtered_o   (filtered_o),
    .channel_out_o(channel_out_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic smp_t hp_filter_predict(smp_t x, logic [CH_W-1:0] ch);
    longint acc;
    longint q;
    if (ch >= CHANNELS_DEF) return '0;
    acc = HP_B[0] * longint'(x);
    for (int k = 1; k <= TAPS; k++) begin
      acc += HP_B[k] * longint'(x_hist[ch][k-1]);
      acc -= HP_A[k-1] * longint'(y_hist[ch][k-1]);
    end
    q = (acc + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    for (int k = TAPS - 1; k >= 1; k--) begin
      x_hist[ch][k] = x_hist[ch][k-1];
      y_hist[ch][k] = y_hist[ch][k-1];
    end
    x_hist[ch][0] = x;
    y_hist[ch][0] = smp_t'(q);
    return smp_t'(q);
  endfunction

  task automatic push_sample(smp_t s, logic [CH_W-1:0] ch);
    int        gap;
    filt_out_t res;
    gap = in_idle ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i <= s;
    channel_i <= ch;
    do @(posedge clk_i); while (!in_ready_o);
    res.filtered = hp_filter_predict(s, ch);
    res.ch = ch;
    pending_results = {pending_results, res};
  endtask

  task automatic stop_samples();
    in_valid_i <= 1'b0;
  endtask

  // result side stalls
  initial begin
    int stall;
    forever begin
      stall = out_idle ? $urandom_range(0, MAX_IDLE) : 0;
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  always @(posedge clk_i) begin
    filt_out_t res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected item: filtered %0d, channel_out %0d", filtered_o, channel_out_o);
        error_count++;
      end else begin
        res = pending_results.pop_front();
        if (filtered_o !== res.filtered) begin
          $error("filtered: expected %0d, actual %0d", res.filtered, filtered_o);
          error_count++;
        end
        if (channel_out_o !== res.ch) begin
          $error("channel_out: expected %0d, actual %0d", res.ch, channel_out_o);
          error_count++;
        end
      end
    end
  end

  task automatic test_extremes();
    push_sample(16'sh7fff, CH0);
    push_sample(-16'sh8000, CH0);
    push_sample(-16'sh8000, CH1);
    push_sample(16'sh7fff, CH1);
    push_sample(16'sd0, CH2);
    push_sample(16'sd1, CH2);
    push_sample(-16'sd1, CH2);
    stop_samples();
  endtask

  task automatic test_unknown_channel();
    push_sample(16'sh7fff, BAD_CH);
    push_sample(-16'sh8000, BAD_CH);
    push_sample(16'sh5a5a, CH2);
    stop_samples();
  endtask

  // alternating full-scale input drives the output into both rails
  task automatic test_saturation();
    for (int i = 0; i < 6; i++) begin
      push_sample((i % 2) ? -16'sh8000 : 16'sh7fff, CH0);
      push_sample((i % 2) ? 16'sh7fff : -16'sh8000, CH1);
    end
    stop_samples();
  endtask

  // back-to-back items on one channel, then a quick channel change
  task automatic test_channel_switching();
    in_idle = 1'b0;
    out_idle = 1'b0;
    push_sample(16'sd1000, CH2);
    push_sample(-16'sd2000, CH2);
    push_sample(16'sd3000, CH2);
    push_sample(16'sd400, CH0);
    push_sample(-16'sd500, CH2);
    stop_samples();
  endtask

  task automatic test_random_stream();
    int              sent;
    int              len;
    stim_mix_e       mix;
    logic [CH_W-1:0] burst_ch;
    logic [CH_W-1:0] ch;
    smp_t            s;
    bit              flip;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      mix = stim_mix_e'($urandom_range(MIX_RANDOM, MIX_ROUND_ROBIN));
      len = $urandom_range(1, 40);
      in_idle = ($urandom_range(0, 3) != 0);
      out_idle = ($urandom_range(0, 3) != 0);
      burst_ch = CH_W'($urandom_range(0, CHANNELS_DEF - 1));
      flip = 1'($urandom_range(0, 1));
      for (int i = 0; i < len; i++) begin
        ch = ($urandom_range(0, 7) == 0) ? BAD_CH : CH_W'($urandom_range(0, CHANNELS_DEF - 1));
        s = smp_t'($urandom);
        case (mix)
          MIX_EXTREME: begin
            s = $urandom_range(0, 1) ? 16'sh7fff : -16'sh8000;
          end
          MIX_NYQUIST: begin
            ch = burst_ch;
            s = ((i % 2) ^ flip) ? -16'sh8000 : 16'sh7fff;
          end
          MIX_TINY: begin
            s = smp_t'($urandom_range(0, 64)) - 16'sd32;
          end
          MIX_SAME_CH: begin
            ch = burst_ch;
          end
          MIX_ROUND_ROBIN: begin
            ch = CH_W'(i % CHANNELS_DEF);
          end
          default: begin
          end
        endcase
        push_sample(s, ch);
        sent++;
      end
    end
    stop_samples();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_unknown_channel();
    test_saturation();
    test_channel_switching();
    test_random_stream();
    for (int i = 0; i < 5000 && pending_results.size() > 0; i++) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (pending_results.size() > 0) begin
      $error("%0d expected items never arrived", pending_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("iir_fourth_order_multichannel_core_tb: done, clean");
    end else begin
      $display("iir_fourth_order_multichannel_core_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("iir_fourth_order_multichannel_core_tb: done, errors");
    $finish;
  end

endmodule
